// ===== rtl/i2c_rm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_rm_pkg
// Shared types and constants of the I2C register master: command codes,
// configuration register map and reset values, transaction payload structs.
// ----------------------------------------------------------------------------
package i2c_rm_pkg;

  // command codes
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_BURST = 2'd3;

  // configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_QUARTER_PERIOD = 2'd1;
  localparam logic [1:0] REG_ACK_TIMEOUT    = 2'd2;

  localparam logic [6:0]  RST_DEVICE_ADDRESS = 7'd50;
  localparam logic [15:0] RST_QUARTER_PERIOD = 16'd5;
  localparam logic [15:0] RST_ACK_TIMEOUT    = 16'd2250;

  typedef struct packed {
    logic [6:0]  device_address;
    logic [15:0] quarter_period_ticks;
    logic [15:0] ack_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] reg_addr;
    logic [7:0] write_byte;
    logic [7:0] byte_count;
    logic       sda_level;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       sda_value;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_data;
    logic       read_last;
    logic       done_res;
    logic       ack_error;
  } res_t;

endpackage

// ===== rtl/i2c_rm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_rm_in_if / i2c_rm_out_if
// Valid/ready channels carrying one timing tick in and one tick result out.
// ----------------------------------------------------------------------------
interface i2c_rm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] reg_addr;
  logic [7:0] write_byte;
  logic [7:0] byte_count;
  logic       sda_level;

  modport source (output valid, output op, output reg_addr, output write_byte,
                  output byte_count, output sda_level, input ready);
  modport sink (input valid, input op, input reg_addr, input write_byte,
                input byte_count, input sda_level, output ready);
endinterface

interface i2c_rm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_drive;
  logic       sda_value;
  logic       busy_res;
  logic       read_valid;
  logic [7:0] read_data;
  logic       read_last;
  logic       done_res;
  logic       ack_error;

  modport source (output valid, output scl_level, output sda_drive, output sda_value,
                  output busy_res, output read_valid, output read_data,
                  output read_last, output done_res, output ack_error, input ready);
  modport sink (input valid, input scl_level, input sda_drive, input sda_value,
                input busy_res, input read_valid, input read_data,
                input read_last, input done_res, input ack_error, output ready);
endinterface

// ===== rtl/i2c_rm_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_rm_cfg_regs
// APB-style configuration registers: device address, slot length, ACK timeout.
// ----------------------------------------------------------------------------
module i2c_rm_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [i2c_rm_pkg::CFG_AW-1:0] paddr,
  input  logic [i2c_rm_pkg::CFG_DW-1:0] pwdata,
  output logic [i2c_rm_pkg::CFG_DW-1:0] prdata,
  output logic                          pready,
  output i2c_rm_pkg::cfg_t              cfg
);

  logic [6:0]  dev_r;
  logic [15:0] qtr_r;
  logic [15:0] tmo_r;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r <= i2c_rm_pkg::RST_DEVICE_ADDRESS;
      qtr_r <= i2c_rm_pkg::RST_QUARTER_PERIOD;
      tmo_r <= i2c_rm_pkg::RST_ACK_TIMEOUT;
    end else if (wr_en) begin
      unique case (reg_idx)
        i2c_rm_pkg::REG_DEVICE_ADDRESS: dev_r <= pwdata[6:0];
        i2c_rm_pkg::REG_QUARTER_PERIOD: qtr_r <= pwdata[15:0];
        i2c_rm_pkg::REG_ACK_TIMEOUT:    tmo_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      i2c_rm_pkg::REG_DEVICE_ADDRESS: prdata = {25'd0, dev_r};
      i2c_rm_pkg::REG_QUARTER_PERIOD: prdata = {16'd0, qtr_r};
      i2c_rm_pkg::REG_ACK_TIMEOUT:    prdata = {16'd0, tmo_r};
      default:                        prdata = '0;
    endcase
  end

  assign cfg.device_address       = dev_r;
  assign cfg.quarter_period_ticks = qtr_r;
  assign cfg.ack_timeout_ticks    = tmo_r;

endmodule

// ===== rtl/i2c_rm_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_rm_engine
// Bit-level I2C master sequencer; advances one step per accepted tick and
// produces the bus levels and status of that tick.
// ----------------------------------------------------------------------------
module i2c_rm_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  i2c_rm_pkg::cmd_t cmd,
  input  i2c_rm_pkg::cfg_t cfg,
  output i2c_rm_pkg::res_t res
);

  localparam logic [4:0] PH_IDLE      = 5'd0;
  localparam logic [4:0] PH_START_A   = 5'd1;
  localparam logic [4:0] PH_START_B   = 5'd2;
  localparam logic [4:0] PH_SEND_PRE  = 5'd3;
  localparam logic [4:0] PH_BIT_SET   = 5'd4;
  localparam logic [4:0] PH_BIT_HIGH  = 5'd5;
  localparam logic [4:0] PH_BIT_LOW   = 5'd6;
  localparam logic [4:0] PH_ACK_SET   = 5'd7;
  localparam logic [4:0] PH_ACK_HIGH  = 5'd8;
  localparam logic [4:0] PH_ACK_POLL  = 5'd9;
  localparam logic [4:0] PH_RD_LOW    = 5'd10;
  localparam logic [4:0] PH_RD_HIGH   = 5'd11;
  localparam logic [4:0] PH_MACK_LOW  = 5'd12;
  localparam logic [4:0] PH_MACK_HIGH = 5'd13;
  localparam logic [4:0] PH_STOP_A    = 5'd14;
  localparam logic [4:0] PH_STOP_B    = 5'd15;
  localparam logic [4:0] PH_STOP_C    = 5'd16;

  logic [4:0]  phase_r, phase_nxt;
  logic [15:0] slot_r, slot_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  raddr_r, raddr_nxt;
  logic [7:0]  wbyte_r, wbyte_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [15:0] ackw_r, ackw_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [1:0]  acks_r, acks_nxt;
  logic        abort_r, abort_nxt;

  logic        start;
  logic [4:0]  ph_cur;
  logic [15:0] slot_cur;
  logic [16:0] slot_sum;
  logic        slot_hit;
  logic [15:0] slot_adv;
  logic [7:0]  rd_shift;
  logic [7:0]  left_dec;
  logic        rw_bit;

  // a command taken while idle already runs its first start slot this tick
  assign start    = (phase_r == PH_IDLE) && (cmd.op != i2c_rm_pkg::OP_NONE);
  assign ph_cur   = start ? PH_START_A : phase_r;
  assign slot_cur = start ? 16'd0 : slot_r;
  assign slot_sum = {1'b0, slot_cur} + 17'd1;
  assign slot_hit = slot_sum >= {1'b0, cfg.quarter_period_ticks};
  assign slot_adv = slot_hit ? 16'd0 : slot_sum[15:0];
  assign rd_shift = {shift_r[6:0], cmd.sda_level};
  assign left_dec = left_r - 8'd1;
  assign rw_bit   = (kind_r == i2c_rm_pkg::OP_BURST) || (acks_r == 2'd2);

  always_comb begin
    phase_nxt = ph_cur;
    slot_nxt  = slot_cur;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    raddr_nxt = raddr_r;
    wbyte_nxt = wbyte_r;
    left_nxt  = left_r;
    ackw_nxt  = ackw_r;
    kind_nxt  = kind_r;
    acks_nxt  = acks_r;
    abort_nxt = abort_r;

    res            = '0;
    res.scl_level  = 1'b1;
    res.sda_drive  = 1'b1;
    res.sda_value  = 1'b1;
    res.busy_res   = 1'b1;

    if (start) begin
      kind_nxt  = cmd.op;
      raddr_nxt = cmd.reg_addr;
      wbyte_nxt = cmd.write_byte;
      left_nxt  = cmd.byte_count;
      acks_nxt  = 2'd0;
      abort_nxt = 1'b0;
    end

    unique case (ph_cur) inside
      PH_START_A: begin
        slot_nxt = slot_adv;
        if (slot_hit) phase_nxt = PH_START_B;
      end
      PH_START_B: begin
        res.sda_value = 1'b0;
        slot_nxt = slot_adv;
        if (slot_hit) begin
          shift_nxt = {cfg.device_address, rw_bit};
          bit_nxt   = 3'd0;
          phase_nxt = PH_SEND_PRE;
        end
      end
      PH_SEND_PRE: begin
        res.scl_level = 1'b0;
        res.sda_value = 1'b0;
        slot_nxt = slot_adv;
        if (slot_hit) phase_nxt = PH_BIT_SET;
      end
      PH_BIT_SET, PH_BIT_HIGH, PH_BIT_LOW: begin
        res.scl_level = (ph_cur == PH_BIT_HIGH);
        res.sda_value = shift_r[7];
        slot_nxt = slot_adv;
        if (slot_hit) begin
          if (ph_cur == PH_BIT_SET) begin
            phase_nxt = PH_BIT_HIGH;
          end else if (ph_cur == PH_BIT_HIGH) begin
            phase_nxt = PH_BIT_LOW;
          end else begin
            shift_nxt = {shift_r[6:0], 1'b0};
            if (bit_r == 3'd7) begin
              bit_nxt   = 3'd0;
              phase_nxt = PH_ACK_SET;
            end else begin
              bit_nxt   = bit_r + 3'd1;
              phase_nxt = PH_BIT_SET;
            end
          end
        end
      end
      PH_ACK_SET: begin
        res.scl_level = 1'b0;
        res.sda_drive = 1'b0;
        res.sda_value = 1'b0;
        slot_nxt = slot_adv;
        if (slot_hit) phase_nxt = PH_ACK_HIGH;
      end
      PH_ACK_HIGH: begin
        res.sda_drive = 1'b0;
        res.sda_value = 1'b0;
        slot_nxt = slot_adv;
        if (slot_hit) begin
          ackw_nxt  = 16'd0;
          phase_nxt = PH_ACK_POLL;
        end
      end
      PH_ACK_POLL: begin
        res.sda_drive = 1'b0;
        res.sda_value = 1'b0;
        if (!cmd.sda_level) begin
          acks_nxt = acks_r + 2'd1;
          slot_nxt = 16'd0;
          phase_nxt = PH_STOP_A;
          case (kind_r)
            i2c_rm_pkg::OP_WRITE: begin
              if (acks_r == 2'd0) begin
                shift_nxt = raddr_r;
                bit_nxt   = 3'd0;
                phase_nxt = PH_SEND_PRE;
              end else if (acks_r == 2'd1) begin
                shift_nxt = wbyte_r;
                bit_nxt   = 3'd0;
                phase_nxt = PH_SEND_PRE;
              end
            end
            i2c_rm_pkg::OP_READ: begin
              if (acks_r == 2'd0) begin
                shift_nxt = raddr_r;
                bit_nxt   = 3'd0;
                phase_nxt = PH_SEND_PRE;
              end else if (acks_r == 2'd1) begin
                phase_nxt = PH_START_A;
              end else begin
                shift_nxt = 8'd0;
                bit_nxt   = 3'd0;
                phase_nxt = PH_RD_LOW;
              end
            end
            i2c_rm_pkg::OP_BURST: begin
              if (left_r != 8'd0) begin
                shift_nxt = 8'd0;
                bit_nxt   = 3'd0;
                phase_nxt = PH_RD_LOW;
              end
            end
            default: ;
          endcase
        end else if (ackw_r >= cfg.ack_timeout_ticks) begin
          abort_nxt = 1'b1;
          slot_nxt  = 16'd0;
          phase_nxt = PH_STOP_A;
        end else begin
          ackw_nxt = ackw_r + 16'd1;
        end
      end
      PH_RD_LOW: begin
        res.scl_level = 1'b0;
        res.sda_drive = 1'b0;
        res.sda_value = 1'b0;
        slot_nxt = slot_adv;
        if (slot_hit) phase_nxt = PH_RD_HIGH;
      end
      PH_RD_HIGH: begin
        res.sda_drive = 1'b0;
        res.sda_value = 1'b0;
        if (slot_cur == 16'd0) begin
          shift_nxt = rd_shift;
          if (bit_r == 3'd7) begin
            bit_nxt        = 3'd0;
            res.read_valid = 1'b1;
            res.read_data  = rd_shift;
            res.read_last  = (kind_r == i2c_rm_pkg::OP_BURST) ? (left_r == 8'd1) : 1'b1;
          end else begin
            bit_nxt = bit_r + 3'd1;
          end
        end
        slot_nxt = slot_adv;
        if (slot_hit) phase_nxt = (bit_nxt == 3'd0) ? PH_MACK_LOW : PH_RD_LOW;
      end
      PH_MACK_LOW: begin
        res.scl_level = 1'b0;
        res.sda_value = 1'b0;
        slot_nxt = slot_adv;
        if (slot_hit) phase_nxt = PH_MACK_HIGH;
      end
      PH_MACK_HIGH: begin
        res.sda_value = 1'b0;
        slot_nxt = slot_adv;
        if (slot_hit) begin
          phase_nxt = PH_STOP_A;
          if (kind_r == i2c_rm_pkg::OP_BURST) begin
            left_nxt = left_dec;
            if (left_dec != 8'd0) begin
              shift_nxt = 8'd0;
              bit_nxt   = 3'd0;
              phase_nxt = PH_RD_LOW;
            end
          end
        end
      end
      PH_STOP_A: begin
        res.scl_level = 1'b0;
        res.sda_value = 1'b0;
        slot_nxt = slot_adv;
        if (slot_hit) phase_nxt = PH_STOP_B;
      end
      PH_STOP_B: begin
        res.sda_value = 1'b0;
        slot_nxt = slot_adv;
        if (slot_hit) phase_nxt = PH_STOP_C;
      end
      PH_STOP_C: begin
        slot_nxt = slot_adv;
        if (slot_hit) begin
          res.done_res  = 1'b1;
          res.ack_error = abort_r;
          phase_nxt     = PH_IDLE;
        end
      end
      default: begin
        res.busy_res = 1'b0;
        phase_nxt    = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      slot_r  <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      raddr_r <= '0;
      wbyte_r <= '0;
      left_r  <= '0;
      ackw_r  <= '0;
      kind_r  <= '0;
      acks_r  <= '0;
      abort_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      slot_r  <= slot_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      raddr_r <= raddr_nxt;
      wbyte_r <= wbyte_nxt;
      left_r  <= left_nxt;
      ackw_r  <= ackw_nxt;
      kind_r  <= kind_nxt;
      acks_r  <= acks_nxt;
      abort_r <= abort_nxt;
    end
  end

endmodule

// ===== rtl/i2c_register_master_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_master_core
// I2C master for register write, register read and burst read; one timing
// tick in, one bus/status transaction out.
// A tick's result is registered into the output register when the tick is accepted.
// Throughput: one tick per clock while results are taken; a waiting result stalls the input.
// A taken result frees the output register in the same cycle for the next tick.
// Reset (rst_n low, synchronous): sequencer idle, output empty, config at
// reset values.
// ----------------------------------------------------------------------------
module i2c_register_master_core (
  input  logic                          clk,
  input  logic                          rst_n,
  i2c_rm_in_if.sink                     in_ch,
  i2c_rm_out_if.source                  out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [i2c_rm_pkg::CFG_AW-1:0] paddr,
  input  logic [i2c_rm_pkg::CFG_DW-1:0] pwdata,
  output logic [i2c_rm_pkg::CFG_DW-1:0] prdata,
  output logic                          pready
);

  i2c_rm_pkg::cfg_t cfg;
  i2c_rm_pkg::cmd_t cmd;
  i2c_rm_pkg::res_t res_nxt;
  i2c_rm_pkg::res_t res_r;
  logic             out_valid_r;
  logic             take;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign take        = in_ch.valid && in_ch.ready;

  assign cmd.op         = in_ch.op;
  assign cmd.reg_addr   = in_ch.reg_addr;
  assign cmd.write_byte = in_ch.write_byte;
  assign cmd.byte_count = in_ch.byte_count;
  assign cmd.sda_level  = in_ch.sda_level;

  i2c_rm_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  i2c_rm_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (take),
    .cmd   (cmd),
    .cfg   (cfg),
    .res   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.scl_level  = res_r.scl_level;
  assign out_ch.sda_drive  = res_r.sda_drive;
  assign out_ch.sda_value  = res_r.sda_value;
  assign out_ch.busy_res   = res_r.busy_res;
  assign out_ch.read_valid = res_r.read_valid;
  assign out_ch.read_data  = res_r.read_data;
  assign out_ch.read_last  = res_r.read_last;
  assign out_ch.done_res   = res_r.done_res;
  assign out_ch.ack_error  = res_r.ack_error;

endmodule

// ===== rtl/i2c_rm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_rm_checker
// Port-level checks of the I2C register master, bound to the top level.
// ----------------------------------------------------------------------------
module i2c_rm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       scl_level,
  input logic       sda_drive,
  input logic       sda_value,
  input logic       busy_res,
  input logic       read_valid,
  input logic [7:0] read_data,
  input logic       done_res,
  input logic       ack_error
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(scl_level) && $stable(sda_value)
      && $stable(read_data) && $stable(done_res))
    else $error("stalled result transaction changed");

  // input only stalls behind a waiting result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  a_status_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (read_valid || done_res) |-> busy_res)
    else $error("read or done status outside a command");

  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ack_error |-> done_res)
    else $error("ack error without done");

  // received bit is sampled with SDA released and SCL high
  a_read_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && read_valid |-> !sda_drive && scl_level)
    else $error("read byte completed while driving SDA");

endmodule

bind i2c_register_master_core i2c_rm_checker u_i2c_rm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .scl_level  (out_ch.scl_level),
  .sda_drive  (out_ch.sda_drive),
  .sda_value  (out_ch.sda_value),
  .busy_res   (out_ch.busy_res),
  .read_valid (out_ch.read_valid),
  .read_data  (out_ch.read_data),
  .done_res   (out_ch.done_res),
  .ack_error  (out_ch.ack_error)
);

// ===== sim/i2c_register_master_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_master_core_tb
// Self-checking bench for the I2C register master. A slave model answers each
// command with ACKs, late ACKs, missing ACKs and random read data. A cycle
// accurate predictor gives the bus levels and status expected for every timing
// tick. A directed table covers field extremes, every command, zero-length
// bursts, zero slot length and zero timeout. Random commands under several
// register settings and stall patterns follow. Register writes are read back.
// ----------------------------------------------------------------------------
module i2c_register_master_core_tb;

  typedef enum logic [4:0] {
    PH_IDLE, PH_START_A, PH_START_B, PH_SEND_PRE, PH_BIT_SET, PH_BIT_HIGH,
    PH_BIT_LOW, PH_ACK_SET, PH_ACK_HIGH, PH_ACK_POLL, PH_RD_LOW, PH_RD_HIGH,
    PH_MACK_LOW, PH_MACK_HIGH, PH_STOP_A, PH_STOP_B, PH_STOP_C
  } bus_phase_t;

  typedef enum logic {ROW_CFG, ROW_CMD} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [1:0]       reg_idx;
    logic [31:0]      reg_val;
    logic [1:0]       op;
    logic [7:0]       reg_addr;
    logic [7:0]       write_byte;
    logic [7:0]       byte_count;
    int               nack_at;
    int               ack_delay;
    bit               chk;
    i2c_rm_pkg::res_t typed;
  } plan_row_t;

  localparam i2c_rm_pkg::res_t RES_IDLE  = i2c_rm_pkg::res_t'({3'b111, 13'd0});
  localparam i2c_rm_pkg::res_t RES_START = i2c_rm_pkg::res_t'({4'b1111, 12'd0});

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [i2c_rm_pkg::CFG_AW-1:0] paddr;
  logic [i2c_rm_pkg::CFG_DW-1:0] pwdata;
  logic [i2c_rm_pkg::CFG_DW-1:0] prdata;
  logic pready;

  i2c_rm_in_if  in_ch ();
  i2c_rm_out_if out_ch ();

  i2c_register_master_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of configuration and engine state
  logic [6:0]  dev_q;
  logic [15:0] qper_q;
  logic [15:0] tmo_q;
  bus_phase_t  ph;
  logic [15:0] slot_q;
  logic [2:0]  bit_q;
  logic [7:0]  shreg;
  logic [7:0]  saved_ra;
  logic [7:0]  saved_wb;
  logic [7:0]  left_q;
  logic [15:0] ackwait_q;
  logic [1:0]  kind_q;
  logic [1:0]  acks_q;
  logic        aborted_q;

  i2c_rm_pkg::res_t bus_expect_q[$];
  plan_row_t        plan[$];

  int send_idle = 0;
  int recv_idle = 0;
  int cur_nack = -1;
  int cur_delay = 0;
  int n_err = 0;
  int n_ticks = 0;
  int n_cmds = 0;
  int n_abort = 0;
  int n_rbytes = 0;
  int n_regwr = 0;
  int n_settings = 0;

  task automatic flag_error(string msg);
    n_err++;
    if (n_err <= 10) $display("tb: mismatch %s", msg);
  endtask

  function automatic void goto_phase(bus_phase_t p);
    ph = p;
    slot_q = '0;
  endfunction

  function automatic bit slot_elapsed();
    if ({1'b0, slot_q} + 17'd1 >= {1'b0, qper_q}) begin
      slot_q = '0;
      return 1'b1;
    end
    slot_q = slot_q + 16'd1;
    return 1'b0;
  endfunction

  function automatic void load_tx(logic [7:0] b);
    shreg = b;
    bit_q = '0;
    goto_phase(PH_SEND_PRE);
  endfunction

  function automatic void begin_rx();
    shreg = '0;
    bit_q = '0;
    goto_phase(PH_RD_LOW);
  endfunction

  function automatic i2c_rm_pkg::res_t predict_tick(i2c_rm_pkg::cmd_t c);
    i2c_rm_pkg::res_t r;
    logic [1:0] n;
    r = RES_START;
    if (ph == PH_IDLE && c.op != i2c_rm_pkg::OP_NONE) begin
      kind_q = c.op;
      saved_ra = c.reg_addr;
      saved_wb = c.write_byte;
      left_q = c.byte_count;
      acks_q = '0;
      aborted_q = 1'b0;
      goto_phase(PH_START_A);
    end
    case (ph)
      PH_START_A: begin
        if (slot_elapsed()) goto_phase(PH_START_B);
      end
      PH_START_B: begin
        r.sda_value = 1'b0;
        if (slot_elapsed())
          load_tx({dev_q, (kind_q == i2c_rm_pkg::OP_BURST || acks_q == 2'd2)});
      end
      PH_SEND_PRE: begin
        r.scl_level = 1'b0;
        r.sda_value = 1'b0;
        if (slot_elapsed()) goto_phase(PH_BIT_SET);
      end
      PH_BIT_SET, PH_BIT_HIGH, PH_BIT_LOW: begin
        r.scl_level = (ph == PH_BIT_HIGH);
        r.sda_value = shreg[7];
        if (slot_elapsed()) begin
          if (ph == PH_BIT_SET) goto_phase(PH_BIT_HIGH);
          else if (ph == PH_BIT_HIGH) goto_phase(PH_BIT_LOW);
          else begin
            shreg = {shreg[6:0], 1'b0};
            if (bit_q == 3'd7) begin
              bit_q = '0;
              goto_phase(PH_ACK_SET);
            end else begin
              bit_q = bit_q + 3'd1;
              goto_phase(PH_BIT_SET);
            end
          end
        end
      end
      PH_ACK_SET: begin
        r.scl_level = 1'b0;
        r.sda_drive = 1'b0;
        r.sda_value = 1'b0;
        if (slot_elapsed()) goto_phase(PH_ACK_HIGH);
      end
      PH_ACK_HIGH: begin
        r.sda_drive = 1'b0;
        r.sda_value = 1'b0;
        if (slot_elapsed()) begin
          ackwait_q = '0;
          goto_phase(PH_ACK_POLL);
        end
      end
      PH_ACK_POLL: begin
        r.sda_drive = 1'b0;
        r.sda_value = 1'b0;
        if (!c.sda_level) begin
          n = acks_q;
          acks_q = acks_q + 2'd1;
          case (kind_q)
            i2c_rm_pkg::OP_WRITE: begin
              if (n == 2'd0) load_tx(saved_ra);
              else if (n == 2'd1) load_tx(saved_wb);
              else goto_phase(PH_STOP_A);
            end
            i2c_rm_pkg::OP_READ: begin
              if (n == 2'd0) load_tx(saved_ra);
              else if (n == 2'd1) goto_phase(PH_START_A);
              else begin_rx();
            end
            i2c_rm_pkg::OP_BURST: begin
              if (left_q == 8'd0) goto_phase(PH_STOP_A);
              else begin_rx();
            end
            default: goto_phase(PH_STOP_A);
          endcase
        end else if (ackwait_q >= tmo_q) begin
          aborted_q = 1'b1;
          goto_phase(PH_STOP_A);
        end else begin
          ackwait_q = ackwait_q + 16'd1;
        end
      end
      PH_RD_LOW: begin
        r.scl_level = 1'b0;
        r.sda_drive = 1'b0;
        r.sda_value = 1'b0;
        if (slot_elapsed()) goto_phase(PH_RD_HIGH);
      end
      PH_RD_HIGH: begin
        r.sda_drive = 1'b0;
        r.sda_value = 1'b0;
        if (slot_q == 16'd0) begin
          shreg = {shreg[6:0], c.sda_level};
          if (bit_q == 3'd7) begin
            bit_q = '0;
            r.read_valid = 1'b1;
            r.read_data = shreg;
            r.read_last = (kind_q == i2c_rm_pkg::OP_BURST) ? (left_q == 8'd1) : 1'b1;
          end else begin
            bit_q = bit_q + 3'd1;
          end
        end
        if (slot_elapsed()) begin
          if (bit_q == 3'd0) goto_phase(PH_MACK_LOW);
          else goto_phase(PH_RD_LOW);
        end
      end
      PH_MACK_LOW: begin
        r.scl_level = 1'b0;
        r.sda_value = 1'b0;
        if (slot_elapsed()) goto_phase(PH_MACK_HIGH);
      end
      PH_MACK_HIGH: begin
        r.sda_value = 1'b0;
        if (slot_elapsed()) begin
          if (kind_q == i2c_rm_pkg::OP_BURST) begin
            left_q = left_q - 8'd1;
            if (left_q == 8'd0) goto_phase(PH_STOP_A);
            else begin_rx();
          end else begin
            goto_phase(PH_STOP_A);
          end
        end
      end
      PH_STOP_A: begin
        r.scl_level = 1'b0;
        r.sda_value = 1'b0;
        if (slot_elapsed()) goto_phase(PH_STOP_B);
      end
      PH_STOP_B: begin
        r.sda_value = 1'b0;
        if (slot_elapsed()) goto_phase(PH_STOP_C);
      end
      PH_STOP_C: begin
        if (slot_elapsed()) begin
          r.done_res = 1'b1;
          r.ack_error = aborted_q;
          goto_phase(PH_IDLE);
        end
      end
      default: begin
        r.busy_res = 1'b0;
        ph = PH_IDLE;
      end
    endcase
    return r;
  endfunction

  // slave answer on sda for the next tick, from the engine state so far
  function automatic logic slave_sda();
    if (ph == PH_ACK_POLL) begin
      if (int'(acks_q) == cur_nack) return 1'b1;
      return (int'(ackwait_q) < cur_delay);
    end
    return 1'($urandom_range(1));
  endfunction

  task automatic send_tick(i2c_rm_pkg::cmd_t c, bit chk, i2c_rm_pkg::res_t typed);
    i2c_rm_pkg::res_t r;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= c.op;
    in_ch.reg_addr   <= c.reg_addr;
    in_ch.write_byte <= c.write_byte;
    in_ch.byte_count <= c.byte_count;
    in_ch.sda_level  <= c.sda_level;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = predict_tick(c);
    bus_expect_q.push_back(chk ? typed : r);
    n_ticks++;
    if (r.done_res && r.ack_error) n_abort++;
    if (r.read_valid) n_rbytes++;
    @(negedge clk);
  endtask

  task automatic run_command(logic [1:0] op, logic [7:0] ra, logic [7:0] wb,
                             logic [7:0] cnt, int nack, int delay, bit chk,
                             i2c_rm_pkg::res_t typed);
    i2c_rm_pkg::cmd_t c;
    cur_nack = nack;
    cur_delay = delay;
    c.op = op;
    c.reg_addr = ra;
    c.write_byte = wb;
    c.byte_count = cnt;
    c.sda_level = 1'($urandom_range(1));
    if (op != i2c_rm_pkg::OP_NONE) n_cmds++;
    send_tick(c, chk, typed);
    while (ph != PH_IDLE) begin
      c.op = ($urandom_range(7) == 0) ? 2'($urandom_range(3)) : i2c_rm_pkg::OP_NONE;
      c.reg_addr = 8'($urandom);
      c.write_byte = 8'($urandom);
      c.byte_count = 8'($urandom);
      c.sda_level = slave_sda();
      send_tick(c, 1'b0, '0);
    end
  endtask

  // write one register once the block has drained, then read it back
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    in_ch.valid <= 1'b0;
    while (bus_expect_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      i2c_rm_pkg::REG_DEVICE_ADDRESS: dev_q = val[6:0];
      i2c_rm_pkg::REG_QUARTER_PERIOD: qper_q = val[15:0];
      i2c_rm_pkg::REG_ACK_TIMEOUT:    tmo_q = val[15:0];
      default: ;
    endcase
    n_regwr++;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== val)
      flag_error($sformatf("readback reg %0d exp %h got %h", idx, val, prdata));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_setting(logic [6:0] dev, logic [15:0] qp, logic [15:0] tmo,
                                int budget);
    int start;
    int nack;
    logic [1:0] op;
    logic [7:0] cnt;
    write_reg(i2c_rm_pkg::REG_DEVICE_ADDRESS, {25'd0, dev});
    write_reg(i2c_rm_pkg::REG_QUARTER_PERIOD, {16'd0, qp});
    write_reg(i2c_rm_pkg::REG_ACK_TIMEOUT, {16'd0, tmo});
    n_settings++;
    start = n_ticks;
    while (n_ticks - start < budget) begin
      op = ($urandom_range(7) == 0) ? i2c_rm_pkg::OP_NONE : 2'($urandom_range(3, 1));
      cnt = ($urandom_range(9) == 0) ? 8'($urandom_range(32)) : 8'($urandom_range(4));
      nack = (tmo_q <= 16'd64 && $urandom_range(5) == 0) ? $urandom_range(2) : -1;
      run_command(op, 8'($urandom), 8'($urandom), cnt, nack, $urandom_range(3),
                  1'b0, '0);
    end
  endtask

  task automatic plan_cfg(logic [1:0] idx, logic [31:0] val);
    plan_row_t p;
    p.kind = ROW_CFG;
    p.reg_idx = idx;
    p.reg_val = val;
    plan.push_back(p);
  endtask

  task automatic plan_cmd(logic [1:0] op, logic [7:0] ra, logic [7:0] wb,
                          logic [7:0] cnt, int nack, int delay, bit chk,
                          i2c_rm_pkg::res_t typed);
    plan_row_t p;
    p.kind = ROW_CMD;
    p.op = op;
    p.reg_addr = ra;
    p.write_byte = wb;
    p.byte_count = cnt;
    p.nack_at = nack;
    p.ack_delay = delay;
    p.chk = chk;
    p.typed = typed;
    plan.push_back(p);
  endtask

  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    i2c_rm_pkg::res_t got;
    i2c_rm_pkg::res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.scl_level, out_ch.sda_drive, out_ch.sda_value, out_ch.busy_res,
             out_ch.read_valid, out_ch.read_data, out_ch.read_last, out_ch.done_res,
             out_ch.ack_error};
      if (bus_expect_q.size() == 0) begin
        flag_error($sformatf("unexpected transaction %h", got));
      end else begin
        want = bus_expect_q.pop_front();
        if (got !== want)
          flag_error($sformatf(
            "scl %b/%b drv %b/%b val %b/%b busy %b/%b rv %b/%b rd %h/%h last %b/%b done %b/%b err %b/%b",
            want.scl_level, got.scl_level, want.sda_drive, got.sda_drive,
            want.sda_value, got.sda_value, want.busy_res, got.busy_res,
            want.read_valid, got.read_valid, want.read_data, got.read_data,
            want.read_last, got.read_last, want.done_res, got.done_res,
            want.ack_error, got.ack_error));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.op <= i2c_rm_pkg::OP_NONE;
    in_ch.reg_addr <= '0;
    in_ch.write_byte <= '0;
    in_ch.byte_count <= '0;
    in_ch.sda_level <= 1'b1;
    dev_q = i2c_rm_pkg::RST_DEVICE_ADDRESS;
    qper_q = i2c_rm_pkg::RST_QUARTER_PERIOD;
    tmo_q = i2c_rm_pkg::RST_ACK_TIMEOUT;
    ph = PH_IDLE;
    slot_q = '0;
    bit_q = '0;
    shreg = '0;
    saved_ra = '0;
    saved_wb = '0;
    left_q = '0;
    ackwait_q = '0;
    kind_q = '0;
    acks_q = '0;
    aborted_q = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    plan_cmd(i2c_rm_pkg::OP_NONE, 8'h00, 8'h00, 8'h00, -1, 0, 1'b1, RES_IDLE);
    plan_cmd(i2c_rm_pkg::OP_WRITE, 8'h3c, 8'hc3, 8'h01, -1, 1, 1'b1, RES_START);
    plan_cfg(i2c_rm_pkg::REG_QUARTER_PERIOD, 32'd1);
    plan_cmd(i2c_rm_pkg::OP_WRITE, 8'h00, 8'hff, 8'h00, -1, 0, 1'b1, RES_START);
    plan_cmd(i2c_rm_pkg::OP_WRITE, 8'hff, 8'h00, 8'hff, -1, 3, 1'b0, '0);
    plan_cmd(i2c_rm_pkg::OP_READ, 8'ha5, 8'h5a, 8'h00, -1, 0, 1'b1, RES_START);
    plan_cmd(i2c_rm_pkg::OP_BURST, 8'h00, 8'h00, 8'h00, -1, 0, 1'b1, RES_START);
    plan_cmd(i2c_rm_pkg::OP_BURST, 8'hff, 8'hff, 8'h01, -1, 2, 1'b0, '0);
    plan_cfg(i2c_rm_pkg::REG_DEVICE_ADDRESS, 32'd0);
    plan_cfg(i2c_rm_pkg::REG_ACK_TIMEOUT, 32'd4);
    plan_cmd(i2c_rm_pkg::OP_WRITE, 8'h55, 8'haa, 8'h00, 0, 0, 1'b0, '0);
    plan_cmd(i2c_rm_pkg::OP_BURST, 8'h12, 8'h34, 8'hff, 0, 0, 1'b0, '0);
    plan_cfg(i2c_rm_pkg::REG_DEVICE_ADDRESS, 32'd127);
    plan_cmd(i2c_rm_pkg::OP_READ, 8'h80, 8'h01, 8'h00, 1, 0, 1'b0, '0);
    plan_cfg(i2c_rm_pkg::REG_ACK_TIMEOUT, 32'd0);
    plan_cmd(i2c_rm_pkg::OP_READ, 8'h7f, 8'hfe, 8'h00, 2, 0, 1'b0, '0);
    plan_cmd(i2c_rm_pkg::OP_BURST, 8'h01, 8'h80, 8'h03, 0, 0, 1'b0, '0);
    plan_cmd(i2c_rm_pkg::OP_WRITE, 8'h0f, 8'hf0, 8'h00, -1, 1, 1'b0, '0);
    plan_cfg(i2c_rm_pkg::REG_QUARTER_PERIOD, 32'd0);
    plan_cmd(i2c_rm_pkg::OP_BURST, 8'hc0, 8'h03, 8'h02, -1, 0, 1'b0, '0);
    plan_cmd(i2c_rm_pkg::OP_WRITE, 8'h99, 8'h66, 8'h00, 2, 0, 1'b0, '0);
    plan_cfg(i2c_rm_pkg::REG_QUARTER_PERIOD, 32'd65535);
    plan_cmd(i2c_rm_pkg::OP_NONE, 8'hff, 8'hff, 8'hff, -1, 0, 1'b1, RES_IDLE);
    plan_cfg(i2c_rm_pkg::REG_QUARTER_PERIOD, 32'd2);
    plan_cfg(i2c_rm_pkg::REG_ACK_TIMEOUT, 32'd65535);
    plan_cmd(i2c_rm_pkg::OP_READ, 8'h44, 8'hbb, 8'h00, -1, 3, 1'b0, '0);

    send_idle = 28;
    recv_idle = 68;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG)
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      else
        run_command(plan[i].op, plan[i].reg_addr, plan[i].write_byte,
                    plan[i].byte_count, plan[i].nack_at, plan[i].ack_delay,
                    plan[i].chk, plan[i].typed);
    end

    random_setting(7'($urandom_range(127)), 16'd1, 16'd3, 20);
    random_setting(7'd127, 16'd2, 16'd0, 20);
    send_idle = 68;
    recv_idle = 28;
    random_setting(7'd0, 16'd1, 16'd65535, 20);
    random_setting(7'($urandom_range(127)), 16'd3, 16'd5, 20);
    send_idle = 0;
    recv_idle = 0;
    random_setting(7'($urandom_range(127)), 16'd0, 16'd1, 20);
    random_setting(7'($urandom_range(127)), 16'd1, 16'd2, 20);

    in_ch.valid <= 1'b0;
    for (int k = 0; k < 100000 && bus_expect_q.size() != 0; k++) @(posedge clk);
    repeat (5) @(posedge clk);
    if (bus_expect_q.size() != 0)
      flag_error($sformatf("%0d transactions never arrived", bus_expect_q.size()));

    $display("tb: %0d ticks, %0d commands, %0d aborted on missing ack, %0d bytes read",
             n_ticks, n_cmds, n_abort, n_rbytes);
    $display("tb: %0d register writes over %0d random settings, %0d mismatches",
             n_regwr, n_settings, n_err);
    if (n_err == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
